// ===== rtl/b64d_pkg.sv =====
// Package for the streaming base64 decoder.
// Holds the beat types, the decoder state and result group types, and the character codes.
// Has no dependencies.
`default_nettype none

package b64d_pkg;

   localparam logic [7:0] CHAR_PAD   = 8'h3d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       run_last;
      logic       failed;
   } rsp_type;

   typedef struct packed {
      logic [1:0]      raw_position;
      logic            plus_held;
      logic [1:0]      group_fill;
      logic [2:0][5:0] sextet_store;
      logic [1:0]      pad_marks;
      logic            padding_seen;
      logic            error_flag;
   } state_type;

   // One group of results caused by a single character: one to three beats.
   typedef struct packed {
      logic            valid;
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            present;
      logic            last;
      logic            failed;
   } group_type;

endpackage

`default_nettype wire

// ===== rtl/b64d_step.sv =====
// Next-state and result logic of the base64 decoder for one input character.
// Purely combinational; depends on b64d_pkg for the state, beat and group types.
`default_nettype none

module b64d_step (
   input  wire b64d_pkg::state_type cur_state,
   input  wire b64d_pkg::req_type   item,
   output b64d_pkg::state_type      next_state,
   output b64d_pkg::group_type      group
);

   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd0;
         if (c >= 8'h41 && c <= 8'h5a) begin
            d = c - 8'h41;
            sextet_of = {1'b0, d[5:0]};
         end else if (c >= 8'h61 && c <= 8'h7a) begin
            d = c - 8'h61 + 8'd26;
            sextet_of = {1'b0, d[5:0]};
         end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
            sextet_of = {1'b0, d[5:0]};
         end else if (c == b64d_pkg::CHAR_PLUS) begin
            sextet_of = {1'b0, b64d_pkg::SEXTET_PLUS};
         end else if (c == b64d_pkg::CHAR_SLASH) begin
            sextet_of = {1'b0, b64d_pkg::SEXTET_SLASH};
         end else begin
            sextet_of = 7'h40;
         end
      end
   endfunction

   always_comb begin
      b64d_pkg::state_type s;
      b64d_pkg::group_type g;
      logic [7:0] c;
      logic       blank;
      logic [6:0] sx;
      logic       finish;
      logic [5:0] d4;

      s      = cur_state;
      g      = '0;
      c      = item.char_code;
      blank  = (c == b64d_pkg::CHAR_CR) || (c == b64d_pkg::CHAR_LF) ||
               (c == b64d_pkg::CHAR_SPACE) || (c == b64d_pkg::CHAR_TAB);
      sx     = sextet_of(c);
      finish = 1'b0;
      d4     = 6'd0;

      // A held plus only exists right after the first raw character, so the
      // group is empty and no error or padding can be pending.
      if (cur_state.plus_held) begin
         s.plus_held = 1'b0;
         if (c != b64d_pkg::CHAR_SPACE) begin
            s.sextet_store[0] = b64d_pkg::SEXTET_PLUS;
            s.group_fill      = 2'd1;
         end
      end

      if (cur_state.raw_position == 2'd0 && c == b64d_pkg::CHAR_PLUS && !item.end_of_text) begin
         s.plus_held = 1'b1;
      end else if (!blank && !s.error_flag) begin
         if (s.padding_seen) begin
            s.error_flag = 1'b1;
         end else if (c == b64d_pkg::CHAR_PAD) begin
            if (s.group_fill < 2'd2) begin
               s.error_flag = 1'b1;
            end else if (s.group_fill == 2'd2) begin
               s.pad_marks[0]    = 1'b1;
               s.sextet_store[2] = 6'd0;
               s.group_fill      = 2'd3;
            end else begin
               s.pad_marks[1] = 1'b1;
               finish         = 1'b1;
            end
         end else if (sx[6]) begin
            s.error_flag = 1'b1;
         end else if (s.group_fill == 2'd3 && s.pad_marks[0]) begin
            s.error_flag = 1'b1;
         end else if (s.group_fill == 2'd3) begin
            d4     = sx[5:0];
            finish = 1'b1;
         end else begin
            case (s.group_fill)
               2'd0:    s.sextet_store[0] = sx[5:0];
               2'd1:    s.sextet_store[1] = sx[5:0];
               default: s.sextet_store[2] = sx[5:0];
            endcase
            s.group_fill = s.group_fill + 2'd1;
         end
      end

      if (finish) begin
         g.valid    = 1'b1;
         g.present  = 1'b1;
         g.bytes[0] = {s.sextet_store[0], s.sextet_store[1][5:4]};
         g.bytes[1] = {s.sextet_store[1][3:0], s.sextet_store[2][5:2]};
         g.bytes[2] = {s.sextet_store[2][1:0], d4};
         if (s.pad_marks[0]) begin
            g.count = 2'd1;
         end else if (s.pad_marks[1]) begin
            g.count = 2'd2;
         end else begin
            g.count = 2'd3;
         end
         if (s.pad_marks != 2'd0) begin
            s.padding_seen = 1'b1;
         end
         s.group_fill = 2'd0;
         s.pad_marks  = 2'd0;
      end

      s.raw_position = (cur_state.raw_position < 2'd2) ? cur_state.raw_position + 2'd1 : 2'd2;

      if (item.end_of_text) begin
         if (s.group_fill != 2'd0) begin
            s.error_flag = 1'b1;
         end
         if (!finish) begin
            g.valid   = 1'b1;
            g.present = 1'b0;
            g.count   = 2'd1;
            g.bytes   = '0;
         end
         g.last   = 1'b1;
         g.failed = s.error_flag;
         s        = '0;
      end

      next_state = s;
      group      = g;
   end

endmodule

`default_nettype wire

// ===== rtl/base64_stream_decoder_core.sv =====
// Top level of the streaming base64 decoder: input register, decoder state and result queue.
// Depends on b64d_pkg and instantiates b64d_step.
`default_nettype none

// The block takes one text character per cycle and decodes standard base64 into bytes,
// one byte per result beat. A character that completes a group of four yields one to
// three beats; the last character of a text always yields at least one beat, which carries
// run_last and the pass or fail status of the whole text. Input and output are decoupled by
// an input register and a two-group result queue, so characters stream at one per cycle as
// long as the consumer takes results at the same rate; only the final burst of three beats
// per group is paced by the one-beat-per-cycle output port. The first result beat of a
// character passes the input register and then the result queue before it is presented.
// Bytes of earlier groups are delivered before a text's failure is known, so a consumer
// drops the text's output when failed is set.
module base64_stream_decoder_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire b64d_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output b64d_pkg::rsp_type      rsp_payload
);

   logic                in_valid_ff, in_valid_in;
   b64d_pkg::req_type   in_ff;
   b64d_pkg::state_type state_ff, state_in;
   b64d_pkg::state_type step_state;
   b64d_pkg::group_type step_group;
   b64d_pkg::group_type queue_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic [1:0]          beat_ff, beat_in;
   b64d_pkg::group_type head;
   logic                advance, push, pop, last_beat;

   b64d_step u_step (
      .cur_state  (state_ff),
      .item       (in_ff),
      .next_state (step_state),
      .group      (step_group)
   );

   assign advance   = in_valid_ff && (!step_group.valid || count_ff != 2'd2);
   assign push      = advance && step_group.valid;
   assign req_ready = !in_valid_ff || advance;

   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_valid = count_ff != 2'd0;
   assign last_beat = beat_ff == head.count - 2'd1;
   assign pop       = rsp_valid && rsp_ready && last_beat;

   always_comb begin
      logic [7:0] data;
      case (beat_ff)
         2'd0:    data = head.bytes[0];
         2'd1:    data = head.bytes[1];
         default: data = head.bytes[2];
      endcase
      rsp_payload.data_byte    = head.present ? data : 8'd0;
      rsp_payload.byte_present = head.present;
      rsp_payload.run_last     = head.last && last_beat;
      rsp_payload.failed       = head.failed && head.last && last_beat;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      state_in  = advance ? step_state : state_ff;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      beat_in   = beat_ff;
      if (rsp_valid && rsp_ready) begin
         beat_in = last_beat ? 2'd0 : beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         count_ff    <= 2'd0;
         beat_ff     <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         beat_ff     <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= step_group;
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_base64_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_decoder_core: streams directed and random texts,
// predicts every result beat in a behavioral decoder and compares them in order.
// Depends on b64d_pkg and the decoder core RTL.

module tb_base64_stream_decoder_core;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_CHARS = 350;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   b64d_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   b64d_pkg::rsp_type rsp_payload;

   b64d_pkg::req_type char_queue[$];
   b64d_pkg::rsp_type expected_bytes[$];
   b64d_pkg::rsp_type char_bytes[$];
   logic [7:0]        text_chars[$];

   int          char_total = 0;
   int          accepted_chars = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          beat_taken = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   logic [15:0] ready_pattern = '1;
   int          pattern_phase = 0;

   logic [1:0] text_pos;
   logic       plus_pending;
   logic [1:0] group_count;
   logic [5:0] group_sextets [3];
   logic [1:0] pad_flags;
   logic       padded_done;
   logic       text_bad;

   base64_stream_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5a) return {1'b1, 6'(c - 8'h41)};
      if (c >= 8'h61 && c <= 8'h7a) return {1'b1, 6'(c - 8'h61 + 8'd26)};
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30 + 8'd52)};
      if (c == b64d_pkg::CHAR_PLUS) return {1'b1, b64d_pkg::SEXTET_PLUS};
      if (c == b64d_pkg::CHAR_SLASH) return {1'b1, b64d_pkg::SEXTET_SLASH};
      return 7'd0;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == b64d_pkg::CHAR_CR || c == b64d_pkg::CHAR_LF ||
             c == b64d_pkg::CHAR_SPACE || c == b64d_pkg::CHAR_TAB;
   endfunction

   function automatic logic [7:0] char_of_sextet(input logic [5:0] v);
      if (v < 6'd26) return 8'h41 + 8'(v);
      if (v < 6'd52) return 8'h61 + 8'(v) - 8'd26;
      if (v < 6'd62) return 8'h30 + 8'(v) - 8'd52;
      if (v == b64d_pkg::SEXTET_PLUS) return b64d_pkg::CHAR_PLUS;
      return b64d_pkg::CHAR_SLASH;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0: return b64d_pkg::CHAR_CR;
         1: return b64d_pkg::CHAR_LF;
         2: return b64d_pkg::CHAR_SPACE;
         default: return b64d_pkg::CHAR_TAB;
      endcase
   endfunction

   task automatic clear_decoder();
      text_pos = 2'd0;
      plus_pending = 1'b0;
      group_count = 2'd0;
      pad_flags = 2'b00;
      padded_done = 1'b0;
      text_bad = 1'b0;
   endtask

   task automatic emit_byte(input logic [7:0] b);
      b64d_pkg::rsp_type r;
      r = '0;
      r.data_byte = b;
      r.byte_present = 1'b1;
      char_bytes.push_back(r);
   endtask

   task automatic complete_group(input logic [5:0] d4);
      emit_byte({group_sextets[0], group_sextets[1][5:4]});
      if (!pad_flags[0]) begin
         emit_byte({group_sextets[1][3:0], group_sextets[2][5:2]});
         if (!pad_flags[1]) emit_byte({group_sextets[2][1:0], d4});
      end
      if (pad_flags != 2'b00) padded_done = 1'b1;
      group_count = 2'd0;
      pad_flags = 2'b00;
   endtask

   task automatic take_symbol(input logic [7:0] c);
      logic [6:0] look;
      look = sextet_lookup(c);
      if (!text_bad) begin
         if (padded_done) begin
            text_bad = 1'b1;
         end else if (c == b64d_pkg::CHAR_PAD) begin
            if (group_count < 2'd2) begin
               text_bad = 1'b1;
            end else if (group_count == 2'd2) begin
               pad_flags[0] = 1'b1;
               group_sextets[2] = '0;
               group_count = 2'd3;
            end else begin
               pad_flags[1] = 1'b1;
               complete_group(6'd0);
            end
         end else if (!look[6]) begin
            text_bad = 1'b1;
         end else if (group_count == 2'd3 && pad_flags[0]) begin
            text_bad = 1'b1;
         end else if (group_count < 2'd3) begin
            group_sextets[group_count] = look[5:0];
            group_count++;
         end else begin
            complete_group(look[5:0]);
         end
      end
   endtask

   task automatic predict_char(input b64d_pkg::req_type item);
      b64d_pkg::rsp_type tail;
      char_bytes = {};
      if (plus_pending) begin
         plus_pending = 1'b0;
         if (item.char_code != b64d_pkg::CHAR_SPACE) take_symbol(b64d_pkg::CHAR_PLUS);
      end
      if (text_pos == 2'd0 && item.char_code == b64d_pkg::CHAR_PLUS && !item.end_of_text)
         plus_pending = 1'b1;
      else if (!is_blank(item.char_code))
         take_symbol(item.char_code);
      if (text_pos != 2'd2) text_pos++;
      if (item.end_of_text) begin
         if (group_count != 2'd0) text_bad = 1'b1;
         if (char_bytes.size() == 0) tail = '0;
         else tail = char_bytes.pop_back();
         tail.run_last = 1'b1;
         tail.failed = text_bad;
         char_bytes.push_back(tail);
         clear_decoder();
      end
      foreach (char_bytes[i]) expected_bytes.push_back(char_bytes[i]);
   endtask

   task automatic queue_text();
      b64d_pkg::req_type item;
      foreach (text_chars[i]) begin
         item.char_code = text_chars[i];
         item.end_of_text = (i == text_chars.size() - 1);
         char_queue.push_back(item);
      end
      char_total += text_chars.size();
      text_chars = {};
   endtask

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
   endtask

   task automatic make_random_text();
      int         kind;
      int         groups;
      int         pads;
      int         spot;
      bit         lead_plus;
      logic [7:0] c;
      kind = $urandom_range(0, 9);
      lead_plus = 1'b0;
      if (kind == 0) begin
         repeat ($urandom_range(1, 6)) text_chars.push_back(8'($urandom));
      end else begin
         case ($urandom_range(0, 3))
            0: push_string("+ ");
            1: lead_plus = 1'b1;
            default: ;
         endcase
         groups = $urandom_range(0, 4);
         pads = $urandom_range(0, 2);
         for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 4; k++) begin
               if (g == groups - 1 && k >= 4 - pads) c = b64d_pkg::CHAR_PAD;
               else if (g == 0 && k == 0 && lead_plus) c = b64d_pkg::CHAR_PLUS;
               else c = char_of_sextet(6'($urandom));
               text_chars.push_back(c);
               if ($urandom_range(0, 7) == 0) text_chars.push_back(blank_char());
            end
         end
         if (groups > 0 && pads > 0 && $urandom_range(0, 5) == 0)
            text_chars.push_back(char_of_sextet(6'($urandom)));
         if ($urandom_range(0, 3) == 0) text_chars.push_back(blank_char());
         if (kind <= 3 && text_chars.size() > 0) begin
            spot = $urandom_range(0, text_chars.size() - 1);
            case (kind)
               1: text_chars[spot] = 8'($urandom);
               2: text_chars.delete(spot);
               default: text_chars.insert(spot, b64d_pkg::CHAR_PAD);
            endcase
         end
      end
      if (text_chars.size() == 0) text_chars.push_back(blank_char());
      queue_text();
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_char(req_payload);
         accepted_chars++;
         beat_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         beat_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (char_queue.size() > 0) begin
            req_payload <= char_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_phase == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pattern = '1;
               1: ready_pattern = 16'($urandom | $urandom);
               2: ready_pattern = 16'($urandom & $urandom);
               default: ready_pattern = 16'($urandom);
            endcase
         end
         rsp_ready <= ready_pattern[pattern_phase];
         pattern_phase = (pattern_phase + 1) % 16;
      end
   end

   always @(posedge clock) begin
      b64d_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result beat: data_byte %h byte_present %b run_last %b failed %b",
                   rsp_payload.data_byte, rsp_payload.byte_present,
                   rsp_payload.run_last, rsp_payload.failed);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            check_field("data_byte", want.data_byte, rsp_payload.data_byte);
            check_field("byte_present", 8'(want.byte_present), 8'(rsp_payload.byte_present));
            check_field("run_last", 8'(want.run_last), 8'(rsp_payload.run_last));
            check_field("failed", 8'(want.failed), 8'(rsp_payload.failed));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int directed_total;
      clear_decoder();
      push_string("+ TQ==");
      queue_text();
      push_string("+/8=");
      queue_text();
      text_chars.push_back(8'hff);
      queue_text();
      text_chars.push_back(8'h00);
      queue_text();
      push_string("z9=B");
      queue_text();
      push_string("AA==\nA");
      queue_text();
      push_string("+");
      queue_text();
      push_string("=");
      queue_text();
      push_string(" ");
      queue_text();
      directed_total = char_total;
      while (char_total < directed_total + RANDOM_CHARS) make_random_text();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_chars == char_total);
      wait (expected_bytes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
